FILE: rtl/dpw_pkg.sv
package dpw_pkg;

    // field widths
    localparam int PIX_W    = 11;
    localparam int DEPTH_W  = 16;
    localparam int ROT_W    = 16;
    localparam int SHIFT_W  = 24;
    localparam int OUT_W    = 24;
    localparam int CFG_W    = 24;

    // default coordinate mask width
    localparam int COORD_BITS_DEF = 11;

    // camera intrinsics in fixed point
    localparam int CX_Q8    = 81564;
    localparam int CY_Q8    = 59897;
    localparam int INVF_Q24 = 44028;

    // divide by five through a reciprocal: q = (h * DIV5_MUL) >> DIV5_SH
    localparam int DIV5_MUL = 26215;
    localparam int DIV5_SH  = 17;

    // internal datapath widths
    localparam int A_W      = PIX_W + 8 + 2;       // offset pixel coordinate, Q.8
    localparam int DINV_W   = 32;                  // depth times inverse focal length
    localparam int PROD_W   = A_W + DINV_W + 1;    // camera product before rounding
    localparam int XC_W     = 24;                  // camera-frame coordinate
    localparam int M_W      = 35;                  // rotation matrix entry, Q.28
    localparam int QP_W     = 2 * ROT_W;           // quaternion component product
    localparam int TERM_W   = M_W + XC_W;          // one term of the matrix-vector product
    localparam int SUM_W    = TERM_W + 2;          // sum of three terms
    localparam int RND_W    = SUM_W - 28;          // after the Q.28 rounding
    localparam int WSUM_W   = RND_W + 1;           // after adding the translation

    localparam int OUT_MAX  = 8388607;
    localparam int OUT_MIN  = -8388608;

    localparam logic signed [M_W-1:0] M_ONE = M_W'(268435456);

    typedef logic signed [M_W-1:0] mcoef_t;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } cfg_reg_t;

    // true when the coordinate is a multiple of ten
    function automatic logic is_mult10(input logic [PIX_W-1:0] val);
        logic [PIX_W-2:0] half;
        logic [PIX_W+DIV5_SH-1:0] prod;
        logic [PIX_W-2:0] quot;
        logic [PIX_W+1:0] back;
        half = val[PIX_W-1:1];
        prod = (PIX_W + DIV5_SH)'(half) * (PIX_W + DIV5_SH)'(DIV5_MUL);
        quot = prod[DIV5_SH +: (PIX_W - 1)];
        back = ((PIX_W + 2)'(quot) << 2) + (PIX_W + 2)'(quot);
        return !val[0] && (back == (PIX_W + 2)'(half));
    endfunction

endpackage

FILE: rtl/dpw_cam.sv
module dpw_cam #(
    parameter int COORD_BITS = dpw_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              in_valid,
    input  logic [dpw_pkg::PIX_W-1:0]         pixel_col,
    input  logic [dpw_pkg::PIX_W-1:0]         pixel_row,
    input  logic [dpw_pkg::DEPTH_W-1:0]       depth_value,
    output logic                              out_valid,
    output logic signed [dpw_pkg::XC_W-1:0]   xc,
    output logic signed [dpw_pkg::XC_W-1:0]   yc,
    output logic signed [dpw_pkg::XC_W-1:0]   zc
);

    localparam int PIX_W   = dpw_pkg::PIX_W;
    localparam int DEPTH_W = dpw_pkg::DEPTH_W;
    localparam int A_W     = dpw_pkg::A_W;
    localparam int DINV_W  = dpw_pkg::DINV_W;
    localparam int PROD_W  = dpw_pkg::PROD_W;
    localparam int XC_W    = dpw_pkg::XC_W;
    localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

    logic [PIX_W-1:0]           u;
    logic [PIX_W-1:0]           v;
    logic                       keep;
    logic signed [A_W-1:0]      ax_next;
    logic signed [A_W-1:0]      ay_next;
    logic [DINV_W-1:0]          dinv_next;

    logic                       s1_valid_reg;
    logic signed [A_W-1:0]      ax_reg;
    logic signed [A_W-1:0]      ay_reg;
    logic [DINV_W-1:0]          dinv_reg;
    logic [DEPTH_W-1:0]         d1_reg;

    logic signed [PROD_W-1:0]   px_next;
    logic signed [PROD_W-1:0]   py_next;
    logic                       s2_valid_reg;
    logic signed [PROD_W-1:0]   px_reg;
    logic signed [PROD_W-1:0]   py_reg;
    logic [DEPTH_W-1:0]         d2_reg;

    logic [PROD_W-1:0]          rx;
    logic [PROD_W-1:0]          ry;
    logic                       s3_valid_reg;
    logic signed [XC_W-1:0]     xc_reg;
    logic signed [XC_W-1:0]     yc_reg;
    logic signed [XC_W-1:0]     zc_reg;

    // stage 1: mask, subsample test, center offset, depth times 1/f
    always_comb begin
        u         = pixel_col & COORD_MASK;
        v         = pixel_row & COORD_MASK;
        keep      = dpw_pkg::is_mult10(u) && dpw_pkg::is_mult10(v);
        ax_next   = $signed(A_W'({u, 8'b0})) - $signed(A_W'(dpw_pkg::CX_Q8));
        ay_next   = $signed(A_W'({v, 8'b0})) - $signed(A_W'(dpw_pkg::CY_Q8));
        dinv_next = DINV_W'(depth_value) * DINV_W'(dpw_pkg::INVF_Q24);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            dinv_reg <= dinv_next;
            d1_reg   <= depth_value;
        end
    end

    // stage 2: offset times scaled depth
    assign px_next = PROD_W'(ax_reg) * PROD_W'($signed({1'b0, dinv_reg}));
    assign py_next = PROD_W'(ay_reg) * PROD_W'($signed({1'b0, dinv_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (ce) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg <= px_next;
            py_reg <= py_next;
            d2_reg <= d1_reg;
        end
    end

    // stage 3: drop 32 fraction bits, round half away from zero
    always_comb begin
        rx = PROD_W'(px_reg) + (PROD_W'(1) << 31) - PROD_W'(px_reg[PROD_W-1]);
        ry = PROD_W'(py_reg) + (PROD_W'(1) << 31) - PROD_W'(py_reg[PROD_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (ce) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            xc_reg <= XC_W'($signed(rx[PROD_W-1:32]));
            yc_reg <= XC_W'($signed(ry[PROD_W-1:32]));
            zc_reg <= $signed(XC_W'(d2_reg));
        end
    end

    assign out_valid = s3_valid_reg;
    assign xc        = xc_reg;
    assign yc        = yc_reg;
    assign zc        = zc_reg;

endmodule

FILE: rtl/dpw_rot.sv
module dpw_rot (
    input  logic                              aclk,
    input  logic signed [dpw_pkg::ROT_W-1:0]  rot_w,
    input  logic signed [dpw_pkg::ROT_W-1:0]  rot_x,
    input  logic signed [dpw_pkg::ROT_W-1:0]  rot_y,
    input  logic signed [dpw_pkg::ROT_W-1:0]  rot_z,
    output dpw_pkg::mcoef_t                   mat [9]
);

    localparam int QP_W = dpw_pkg::QP_W;
    localparam int M_W  = dpw_pkg::M_W;

    logic signed [QP_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [QP_W-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [QP_W-1:0] wx_reg, wy_reg, wz_reg;
    dpw_pkg::mcoef_t        mat_next [9];
    dpw_pkg::mcoef_t        mat_reg  [9];

    // component products, refreshed every cycle from the pose registers
    always_ff @(posedge aclk) begin
        xx_reg <= QP_W'(rot_x) * QP_W'(rot_x);
        yy_reg <= QP_W'(rot_y) * QP_W'(rot_y);
        zz_reg <= QP_W'(rot_z) * QP_W'(rot_z);
        xy_reg <= QP_W'(rot_x) * QP_W'(rot_y);
        xz_reg <= QP_W'(rot_x) * QP_W'(rot_z);
        yz_reg <= QP_W'(rot_y) * QP_W'(rot_z);
        wx_reg <= QP_W'(rot_w) * QP_W'(rot_x);
        wy_reg <= QP_W'(rot_w) * QP_W'(rot_y);
        wz_reg <= QP_W'(rot_w) * QP_W'(rot_z);
    end

    // unit-quaternion rotation matrix in Q.28, row major
    always_comb begin
        mat_next[0] = dpw_pkg::M_ONE - ((M_W'(yy_reg) + M_W'(zz_reg)) <<< 1);
        mat_next[1] = (M_W'(xy_reg) - M_W'(wz_reg)) <<< 1;
        mat_next[2] = (M_W'(xz_reg) + M_W'(wy_reg)) <<< 1;
        mat_next[3] = (M_W'(xy_reg) + M_W'(wz_reg)) <<< 1;
        mat_next[4] = dpw_pkg::M_ONE - ((M_W'(xx_reg) + M_W'(zz_reg)) <<< 1);
        mat_next[5] = (M_W'(yz_reg) - M_W'(wx_reg)) <<< 1;
        mat_next[6] = (M_W'(xz_reg) - M_W'(wy_reg)) <<< 1;
        mat_next[7] = (M_W'(yz_reg) + M_W'(wx_reg)) <<< 1;
        mat_next[8] = dpw_pkg::M_ONE - ((M_W'(xx_reg) + M_W'(yy_reg)) <<< 1);
    end

    always_ff @(posedge aclk) begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

FILE: rtl/dpw_xform.sv
module dpw_xform (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic signed [dpw_pkg::XC_W-1:0]     xc,
    input  logic signed [dpw_pkg::XC_W-1:0]     yc,
    input  logic signed [dpw_pkg::XC_W-1:0]     zc,
    input  dpw_pkg::mcoef_t                     mat [9],
    input  logic signed [dpw_pkg::SHIFT_W-1:0]  shift_x,
    input  logic signed [dpw_pkg::SHIFT_W-1:0]  shift_y,
    input  logic signed [dpw_pkg::SHIFT_W-1:0]  shift_z,
    output logic                                out_valid,
    output logic signed [dpw_pkg::OUT_W-1:0]    world_x,
    output logic signed [dpw_pkg::OUT_W-1:0]    world_y,
    output logic signed [dpw_pkg::OUT_W-1:0]    world_z
);

    localparam int TERM_W  = dpw_pkg::TERM_W;
    localparam int SUM_W   = dpw_pkg::SUM_W;
    localparam int RND_W   = dpw_pkg::RND_W;
    localparam int WSUM_W  = dpw_pkg::WSUM_W;
    localparam int OUT_W   = dpw_pkg::OUT_W;
    localparam logic signed [WSUM_W-1:0] SAT_HI = WSUM_W'(dpw_pkg::OUT_MAX);
    localparam logic signed [WSUM_W-1:0] SAT_LO = WSUM_W'(dpw_pkg::OUT_MIN);

    logic signed [TERM_W-1:0] term_reg [9];
    logic signed [SUM_W-1:0]  sum_reg  [3];
    logic [SUM_W-1:0]         rnd      [3];
    logic signed [RND_W-1:0]  rnd_reg  [3];
    logic signed [WSUM_W-1:0] wsum     [3];
    logic signed [OUT_W-1:0]  sat      [3];
    logic signed [OUT_W-1:0]  out_reg  [3];
    logic                     t4_valid_reg;
    logic                     t5_valid_reg;
    logic                     t6_valid_reg;
    logic                     t7_valid_reg;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            t6_valid_reg <= 1'b0;
            t7_valid_reg <= 1'b0;
        end else if (ce) begin
            t4_valid_reg <= in_valid;
            t5_valid_reg <= t4_valid_reg;
            t6_valid_reg <= t5_valid_reg;
            t7_valid_reg <= t6_valid_reg;
        end
    end

    // stage 4: the nine products of the matrix-vector product
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                term_reg[3*r]     <= TERM_W'(mat[3*r])     * TERM_W'(xc);
                term_reg[3*r + 1] <= TERM_W'(mat[3*r + 1]) * TERM_W'(yc);
                term_reg[3*r + 2] <= TERM_W'(mat[3*r + 2]) * TERM_W'(zc);
            end
        end
    end

    // stage 5: row sums
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                sum_reg[r] <= SUM_W'(term_reg[3*r]) + SUM_W'(term_reg[3*r + 1])
                            + SUM_W'(term_reg[3*r + 2]);
            end
        end
    end

    // stage 6: back from Q.28, round half away from zero
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rnd[r] = SUM_W'(sum_reg[r]) + (SUM_W'(1) << 27) - SUM_W'(sum_reg[r][SUM_W-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                rnd_reg[r] <= $signed(rnd[r][SUM_W-1:28]);
            end
        end
    end

    // stage 7: add translation and saturate
    always_comb begin
        wsum[0] = WSUM_W'(rnd_reg[0]) + WSUM_W'(shift_x);
        wsum[1] = WSUM_W'(rnd_reg[1]) + WSUM_W'(shift_y);
        wsum[2] = WSUM_W'(rnd_reg[2]) + WSUM_W'(shift_z);
        for (int r = 0; r < 3; r++) begin
            if (wsum[r] > SAT_HI) begin
                sat[r] = OUT_W'(SAT_HI);
            end else if (wsum[r] < SAT_LO) begin
                sat[r] = OUT_W'(SAT_LO);
            end else begin
                sat[r] = OUT_W'(wsum[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= sat;
        end
    end

    assign out_valid = t7_valid_reg;
    assign world_x   = out_reg[0];
    assign world_y   = out_reg[1];
    assign world_z   = out_reg[2];

endmodule

FILE: rtl/depth_pixel_to_world_point.sv
// Depth pixel to world point.
// The s_ channel takes one depth pixel per transfer (column, row, depth) in
// raster order. Pixels whose column and row are not both multiples of ten
// are dropped inside the pipeline and produce no output transfer. Each kept
// pixel is back-projected through the fixed pinhole intrinsics, rotated by
// the pose quaternion and shifted by the pose translation; the m_ channel
// carries one saturated world point per kept pixel, in input order.
// Pose registers are loaded through cfg_wr_en / cfg_wr_index / cfg_wr_data;
// the user must load them only while no pixel is in flight, as the block
// does not enforce it. The rotation matrix follows them through its own
// product and matrix registers. Throughput: one pixel per clock unless a
// receiver stall holds the pipeline. Pipeline: seven register stages
// (three back-projection, four rotate/translate).
// The whole pipeline moves on one enable: it advances while the output
// register is empty or m_tready is high, so a receiver stall freezes every
// stage and holds s_tready low without losing or repeating a pixel.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// identity rotation and zero translation.
module depth_pixel_to_world_point #(
    parameter int COORD_BITS = dpw_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pixel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,   // pixel_col, pixel_row, depth_value, pad
    // world point output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,   // world_x, world_y, world_z
    // pose register writes
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_wr_index,
    input  logic [dpw_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int PIX_W   = dpw_pkg::PIX_W;
    localparam int DEPTH_W = dpw_pkg::DEPTH_W;
    localparam int ROT_W   = dpw_pkg::ROT_W;
    localparam int SHIFT_W = dpw_pkg::SHIFT_W;
    localparam int XC_W    = dpw_pkg::XC_W;
    localparam int OUT_W   = dpw_pkg::OUT_W;

    logic signed [ROT_W-1:0]   rot_w_reg, rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [SHIFT_W-1:0] shift_x_reg, shift_y_reg, shift_z_reg;

    logic                      ce;
    logic                      cam_valid;
    logic signed [XC_W-1:0]    xc, yc, zc;
    dpw_pkg::mcoef_t           mat [9];
    logic signed [OUT_W-1:0]   world_x, world_y, world_z;

    // pose registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_w_reg   <= ROT_W'(16384);
            rot_x_reg   <= '0;
            rot_y_reg   <= '0;
            rot_z_reg   <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
        end else if (cfg_wr_en) begin
            case (dpw_pkg::cfg_reg_t'(cfg_wr_index))
                dpw_pkg::REG_ROT_W:   rot_w_reg   <= cfg_wr_data[ROT_W-1:0];
                dpw_pkg::REG_ROT_X:   rot_x_reg   <= cfg_wr_data[ROT_W-1:0];
                dpw_pkg::REG_ROT_Y:   rot_y_reg   <= cfg_wr_data[ROT_W-1:0];
                dpw_pkg::REG_ROT_Z:   rot_z_reg   <= cfg_wr_data[ROT_W-1:0];
                dpw_pkg::REG_SHIFT_X: shift_x_reg <= cfg_wr_data[SHIFT_W-1:0];
                dpw_pkg::REG_SHIFT_Y: shift_y_reg <= cfg_wr_data[SHIFT_W-1:0];
                dpw_pkg::REG_SHIFT_Z: shift_z_reg <= cfg_wr_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // global pipeline enable
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    dpw_cam #(
        .COORD_BITS (COORD_BITS)
    ) u_cam (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .in_valid    (s_tvalid),
        .pixel_col   (s_tdata[PIX_W-1:0]),
        .pixel_row   (s_tdata[2*PIX_W-1:PIX_W]),
        .depth_value (s_tdata[2*PIX_W+DEPTH_W-1:2*PIX_W]),
        .out_valid   (cam_valid),
        .xc          (xc),
        .yc          (yc),
        .zc          (zc)
    );

    dpw_rot u_rot (
        .aclk  (aclk),
        .rot_w (rot_w_reg),
        .rot_x (rot_x_reg),
        .rot_y (rot_y_reg),
        .rot_z (rot_z_reg),
        .mat   (mat)
    );

    dpw_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (cam_valid),
        .xc        (xc),
        .yc        (yc),
        .zc        (zc),
        .mat       (mat),
        .shift_x   (shift_x_reg),
        .shift_y   (shift_y_reg),
        .shift_z   (shift_z_reg),
        .out_valid (m_tvalid),
        .world_x   (world_x),
        .world_y   (world_y),
        .world_z   (world_z)
    );

    assign m_tdata = {world_z, world_y, world_x};

endmodule
